FILE: sv/safr_pkg.sv
// Package: shared types, byte codes and the learn-off frame table of the receiver.
`timescale 1ns / 1ps
`default_nettype none

package safr_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 32;

  localparam logic [7:0] SOF_BYTE = 8'h01;
  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] NAK_BYTE = 8'h15;
  localparam logic [7:0] CAN_BYTE = 8'h18;

  localparam logic [7:0] FUNC_APP_CMD = 8'h04;
  localparam logic [7:0] FUNC_SEND_DATA = 8'h13;
  localparam logic [7:0] FUNC_MEMORY_ID = 8'h20;
  localparam logic [7:0] FUNC_NODE_INFO = 8'h49;
  localparam logic [7:0] FUNC_LEARN = 8'h50;

  localparam logic [7:0] FRAME_REQUEST = 8'h00;
  localparam logic [7:0] LEARN_FRAME_LEN = 8'h05;
  localparam logic [7:0] LEARN_OFF = 8'h00;
  localparam logic [7:0] LRC_SEED = 8'hff;
  localparam logic [7:0] LEARN_STOP = 8'h06;
  localparam logic [7:0] LEARN_BLOCKED = 8'h01;

  localparam logic [7:0] BACKOFF_MAX = 8'd128;
  localparam logic [7:0] BACKOFF_MIN = 8'd1;
  localparam logic [7:0] SEQ_RESET = 8'd42;

  localparam int APP_HDR_BYTES = 5;
  localparam int LEARN_FRAME_BYTES = 7;

  localparam logic [2:0] KIND_STATUS = 3'd0;
  localparam logic [2:0] KIND_ACK = 3'd1;
  localparam logic [2:0] KIND_APP = 3'd2;
  localparam logic [2:0] KIND_NODE = 3'd3;
  localparam logic [2:0] KIND_LEARN = 3'd4;

  typedef struct packed {
    logic step;
    logic load_first;
    logic rd;
    logic load_burst;
  } cmd_t;

  typedef struct packed {
    logic more;
  } stat_t;

  function automatic logic [7:0] learn_byte(input logic [2:0] i, input logic [7:0] s);
    logic [7:0] b;
    case (i)
      3'd0: b = SOF_BYTE;
      3'd1: b = LEARN_FRAME_LEN;
      3'd2: b = FRAME_REQUEST;
      3'd3: b = FUNC_LEARN;
      3'd4: b = LEARN_OFF;
      3'd5: b = s;
      default: b = LRC_SEED ^ LEARN_FRAME_LEN ^ FRAME_REQUEST ^ FUNC_LEARN ^ LEARN_OFF ^ s;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: sv/safr_if.sv
// Interfaces: input item channel and result item channel.
`timescale 1ns / 1ps
`default_nettype none

interface safr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;
  logic       process_messages;

  modport source(output valid, req_type, rx_byte, process_messages, input ready);
  modport sink(input valid, req_type, rx_byte, process_messages, output ready);
endinterface

interface safr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] byte_value;
  logic       last;
  logic [6:0] src_node;
  logic [7:0] nvc_command;
  logic       ack_got;
  logic [7:0] backoff_ms;
  logic [7:0] send_status;
  logic       send_status_valid;
  logic [7:0] own_address;
  logic       own_address_valid;
  logic       learn_block;

  modport source(output valid, kind, byte_value, last, src_node, nvc_command, ack_got,
                 backoff_ms, send_status, send_status_valid, own_address,
                 own_address_valid, learn_block, input ready);
  modport sink(input valid, kind, byte_value, last, src_node, nvc_command, ack_got,
               backoff_ms, send_status, send_status_valid, own_address,
               own_address_valid, learn_block, output ready);
endinterface

`default_nettype wire

FILE: sv/safr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module safr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/safr_dp.sv
// Datapath: frame parser registers, link status, payload store and result register.
`timescale 1ns / 1ps
`default_nettype none

module safr_dp
  import safr_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  output stat_t           st,
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] rx_byte,
  input  wire logic       process_messages,
  input  wire logic       app_en,
  input  wire logic       node_en,
  output logic      [2:0] kind,
  output logic      [7:0] byte_value,
  output logic            last,
  output logic      [6:0] src_node,
  output logic      [7:0] nvc_command,
  output logic            ack_got,
  output logic      [7:0] backoff_ms,
  output logic      [7:0] send_status,
  output logic            send_status_valid,
  output logic      [7:0] own_address,
  output logic            own_address_valid,
  output logic            learn_block
);

  localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);
  localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PAYLOAD_DEPTH);

  localparam logic [2:0] ST_ACK = 3'd0;
  localparam logic [2:0] ST_SOF = 3'd1;
  localparam logic [2:0] ST_LEN = 3'd2;
  localparam logic [2:0] ST_TYPE = 3'd3;
  localparam logic [2:0] ST_CMD = 3'd4;
  localparam logic [2:0] ST_DATA = 3'd5;
  localparam logic [2:0] ST_LRC = 3'd6;

  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_SENT = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  localparam logic [1:0] BK_APP = 2'd0;
  localparam logic [1:0] BK_NODE = 2'd1;
  localparam logic [1:0] BK_LEARN = 2'd2;

  logic [2:0]       pstate, pstate_next;
  logic [7:0]       rem, rem_next;
  logic [7:0]       ftype, ftype_next;
  logic [7:0]       fcmd, fcmd_next;
  logic [CNT_W-1:0] count, count_next;
  logic             ack_flag, ack_flag_next;
  logic [7:0]       backoff, backoff_next;
  logic [7:0]       seq, seq_next;
  logic [7:0]       seq_saved, seq_saved_next;
  logic             blocked, blocked_next;
  logic [7:0]       ss, ss_next;
  logic             ss_v, ss_v_next;
  logic [7:0]       oa, oa_next;
  logic             oa_v, oa_v_next;
  logic [7:0]       pl1, pl1_next;
  logic [7:0]       pl4, pl4_next;
  logic             first_ack, first_ack_next;
  logic             burst_act, burst_act_next;
  logic [1:0]       burst_kind, burst_kind_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] idx_end, idx_end_next;

  logic             ram_we;
  logic [7:0]       ram_rdata;
  logic [7:0]       rem_dec;
  logic [CNT_W-1:0] idx_inc;

  assign rem_dec = rem - 8'd1;
  assign idx_inc = idx + CNT_W'(1);
  assign ram_we = cmd.step && (req_type == REQ_BYTE) && (pstate == ST_DATA) &&
                  (count < DEPTH_C);
  assign st.more = burst_act && (idx != idx_end);

  safr_ram #(
    .WIDTH(8),
    .DEPTH(PAYLOAD_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(rx_byte),
    .raddr(idx[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    pstate_next = pstate;
    rem_next = rem;
    ftype_next = ftype;
    fcmd_next = fcmd;
    count_next = count;
    ack_flag_next = ack_flag;
    backoff_next = backoff;
    seq_next = seq;
    seq_saved_next = seq_saved;
    blocked_next = blocked;
    ss_next = ss;
    ss_v_next = ss_v;
    oa_next = oa;
    oa_v_next = oa_v;
    pl1_next = pl1;
    pl4_next = pl4;
    first_ack_next = first_ack;
    burst_act_next = burst_act;
    burst_kind_next = burst_kind;
    idx_next = idx;
    idx_end_next = idx_end;
    if (cmd.step) begin
      first_ack_next = 1'b0;
      burst_act_next = 1'b0;
      case (req_type)
        REQ_BYTE: begin
          unique case (pstate)
            ST_ACK: begin
              if (rx_byte == ACK_BYTE) begin
                pstate_next = ST_SOF;
                backoff_next = BACKOFF_MIN;
                ack_flag_next = 1'b1;
              end else if (rx_byte == NAK_BYTE || rx_byte == CAN_BYTE) begin
                if (backoff != BACKOFF_MAX) begin
                  backoff_next = {backoff[6:0], 1'b0};
                end
                pstate_next = ST_SOF;
                ack_flag_next = 1'b0;
              end else if (rx_byte == SOF_BYTE) begin
                pstate_next = ST_LEN;
                rem_next = 8'd0;
              end
            end
            ST_LEN: begin
              rem_next = rx_byte - 8'd3;
              pstate_next = ST_TYPE;
            end
            ST_TYPE: begin
              ftype_next = rx_byte;
              pstate_next = ST_CMD;
            end
            ST_CMD: begin
              fcmd_next = rx_byte;
              count_next = '0;
              pstate_next = (rem == 8'd0) ? ST_LRC : ST_DATA;
            end
            ST_DATA: begin
              if (count < DEPTH_C) begin
                count_next = count + CNT_W'(1);
                if (count == CNT_W'(1)) pl1_next = rx_byte;
                if (count == CNT_W'(4)) pl4_next = rx_byte;
              end
              rem_next = rem_dec;
              if (rem_dec == 8'd0) pstate_next = ST_LRC;
            end
            ST_LRC: begin
              pstate_next = ST_SOF;
              first_ack_next = 1'b1;
              if (ftype == FRAME_REQUEST && fcmd == FUNC_SEND_DATA) begin
                ss_next = pl1;
                ss_v_next = 1'b1;
              end
              if (ftype == FRAME_REQUEST && fcmd == FUNC_APP_CMD && app_en && !pl1[7] &&
                  process_messages && count >= CNT_W'(APP_HDR_BYTES)) begin
                burst_act_next = 1'b1;
                burst_kind_next = BK_APP;
                idx_next = CNT_W'(APP_HDR_BYTES);
                idx_end_next = count;
              end
              if (fcmd == FUNC_MEMORY_ID) begin
                oa_next = pl4;
                oa_v_next = 1'b1;
              end
              if (fcmd == FUNC_NODE_INFO && node_en) begin
                burst_act_next = 1'b1;
                burst_kind_next = BK_NODE;
                idx_next = '0;
                idx_end_next = count;
              end
              if (fcmd == FUNC_LEARN) begin
                if (pl1 == LEARN_BLOCKED) begin
                  blocked_next = 1'b1;
                end else if (pl1 == LEARN_STOP) begin
                  burst_act_next = 1'b1;
                  burst_kind_next = BK_LEARN;
                  idx_next = '0;
                  idx_end_next = CNT_W'(LEARN_FRAME_BYTES);
                  seq_saved_next = seq;
                  seq_next = seq + 8'd1;
                  blocked_next = 1'b0;
                end
              end
            end
            default: begin
              if (rx_byte == SOF_BYTE) begin
                pstate_next = ST_LEN;
                rem_next = 8'd0;
              end else if (rx_byte == ACK_BYTE) begin
                ack_flag_next = 1'b1;
              end
            end
          endcase
        end
        REQ_SENT: begin
          pstate_next = ST_ACK;
          ack_flag_next = 1'b0;
        end
        REQ_TIMEOUT: begin
          if (pstate == ST_ACK) pstate_next = ST_SOF;
        end
        default: begin
        end
      endcase
    end
    if (cmd.load_burst) begin
      idx_next = idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= ST_SOF;
      rem <= '0;
      ftype <= '0;
      fcmd <= '0;
      count <= '0;
      ack_flag <= 1'b0;
      backoff <= BACKOFF_MIN;
      seq <= SEQ_RESET;
      blocked <= 1'b0;
      ss <= '0;
      ss_v <= 1'b0;
      oa <= '0;
      oa_v <= 1'b0;
      first_ack <= 1'b0;
      burst_act <= 1'b0;
      burst_kind <= BK_APP;
      idx <= '0;
      idx_end <= '0;
    end else begin
      pstate <= pstate_next;
      rem <= rem_next;
      ftype <= ftype_next;
      fcmd <= fcmd_next;
      count <= count_next;
      ack_flag <= ack_flag_next;
      backoff <= backoff_next;
      seq <= seq_next;
      blocked <= blocked_next;
      ss <= ss_next;
      ss_v <= ss_v_next;
      oa <= oa_next;
      oa_v <= oa_v_next;
      first_ack <= first_ack_next;
      burst_act <= burst_act_next;
      burst_kind <= burst_kind_next;
      idx <= idx_next;
      idx_end <= idx_end_next;
    end
  end

  // payload shadows of bytes 1 and 4, the saved sequence number, and the result register
  always_ff @(posedge clk) begin
    pl1 <= pl1_next;
    pl4 <= pl4_next;
    seq_saved <= seq_saved_next;
    if (cmd.load_first) begin
      kind <= first_ack ? KIND_ACK : KIND_STATUS;
      byte_value <= first_ack ? ACK_BYTE : 8'h00;
      last <= !st.more;
      src_node <= '0;
      nvc_command <= '0;
    end else if (cmd.load_burst) begin
      last <= (idx_inc == idx_end);
      case (burst_kind)
        BK_APP: begin
          kind <= KIND_APP;
          byte_value <= ram_rdata;
          src_node <= pl1[6:0];
          nvc_command <= pl4;
        end
        BK_NODE: begin
          kind <= KIND_NODE;
          byte_value <= ram_rdata;
          src_node <= '0;
          nvc_command <= '0;
        end
        default: begin
          kind <= KIND_LEARN;
          byte_value <= learn_byte(idx[2:0], seq_saved);
          src_node <= '0;
          nvc_command <= '0;
        end
      endcase
    end
  end

  assign ack_got = ack_flag;
  assign backoff_ms = backoff;
  assign send_status = ss;
  assign send_status_valid = ss_v;
  assign own_address = oa;
  assign own_address_valid = oa_v;
  assign learn_block = blocked;

endmodule

`default_nettype wire

FILE: sv/safr_ctrl.sv
// Controller: sequences item acceptance, payload reads and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module safr_ctrl
  import safr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t st,
  output cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_HOLD = 3'd2;
  localparam logic [2:0] S_RD = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_HOLD);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step = 1'b1;
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        cmd.load_first = 1'b1;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready) state_next = st.more ? S_RD : S_IDLE;
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_burst = 1'b1;
        state_next = S_HOLD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_hold_until_taken: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("pending result dropped");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !st.more) |=> in_ready)
    else $error("item not closed after final result");

  a_load_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.load_burst |-> $past(cmd.rd))
    else $error("burst result loaded without payload read");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> (!in_ready && !out_valid))
    else $error("accept overlapped with result");

endmodule

`default_nettype wire

FILE: sv/serial_api_frame_receiver.sv
// Top level: serial API frame receiver with APB configuration registers.
// Flow: the first result item is offered once the controller has passed from S_IDLE
// through S_FIRST, where the result register is loaded, into S_HOLD; no new input item is
// accepted until the last result of an item is taken (up to 33 results per item); each
// extra result costs one payload RAM read and one load of the single result register.
// Reset: synchronous, active high; clears parser and link status, sets backoff to 1
// and sequence number to 42; the payload RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module serial_api_frame_receiver
  import safr_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  safr_in_if.sink          in_ch,
  safr_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cmd_t  cmd;
  stat_t st;
  logic  app_en;
  logic  node_en;

  assign pready = 1'b1;

  // register 0 at byte 0, register 1 at byte 4
  always_ff @(posedge clk) begin
    if (rst) begin
      app_en <= 1'b0;
      node_en <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        node_en <= pwdata[0];
      end else begin
        app_en <= pwdata[0];
      end
    end
  end

  assign prdata = {31'd0, paddr[2] ? node_en : app_en};

  safr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  safr_dp #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .req_type         (in_ch.req_type),
    .rx_byte          (in_ch.rx_byte),
    .process_messages (in_ch.process_messages),
    .app_en           (app_en),
    .node_en          (node_en),
    .kind             (out_ch.kind),
    .byte_value       (out_ch.byte_value),
    .last             (out_ch.last),
    .src_node         (out_ch.src_node),
    .nvc_command      (out_ch.nvc_command),
    .ack_got          (out_ch.ack_got),
    .backoff_ms       (out_ch.backoff_ms),
    .send_status      (out_ch.send_status),
    .send_status_valid(out_ch.send_status_valid),
    .own_address      (out_ch.own_address),
    .own_address_valid(out_ch.own_address_valid),
    .learn_block      (out_ch.learn_block)
  );

endmodule

`default_nettype wire
